[design/lop_pkg.sv]
// Shared types, constants and helpers for the linear output predictor.
package lop_pkg;

	localparam int FIELD_LANES = 4;
	localparam int DEF_LANES   = 4;
	localparam int VALUE_W     = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int ABS_TOL_W   = 31;
	localparam int REL_TOL_W   = 16;

	localparam logic [ABS_TOL_W-1:0] ABS_TOL_RESET = ABS_TOL_W'(7);
	localparam logic [REL_TOL_W-1:0] REL_TOL_RESET = REL_TOL_W'(1311);

	typedef logic signed [VALUE_W-1:0] value_t;

	localparam value_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam value_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_LANE0 = 3'd0,
		REG_COEF_LANE1 = 3'd1,
		REG_COEF_LANE2 = 3'd2,
		REG_COEF_LANE3 = 3'd3,
		REG_TIME_COEF  = 3'd4,
		REG_ABS_TOL    = 3'd5,
		REG_REL_TOL    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic               mode;
		logic [VALUE_W-1:0] time_now;
		value_t             dep_value_0;
		value_t             dep_value_1;
		value_t             dep_value_2;
		value_t             dep_value_3;
		value_t             measured;
	} req_t;

	typedef struct packed {
		value_t predicted;
		logic   mismatch;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_MUL,
		S_TERM,
		S_SUM,
		S_ERR,
		S_CMP
	} state_t;

	typedef struct packed {
		logic load;
		logic add;
		logic err;
	} merge_ctrl_t;

	function automatic value_t sat_add(value_t a, value_t b);
		logic signed [VALUE_W:0] s;
		s = $signed({a[VALUE_W-1], a}) + $signed({b[VALUE_W-1], b});
		if (s[VALUE_W] != s[VALUE_W-1]) begin
			return s[VALUE_W] ? VAL_MIN : VAL_MAX;
		end
		return s[VALUE_W-1:0];
	endfunction

endpackage

[design/linear_output_predictor_unit.sv]
// Linear output predictor: the last measurement plus coefficient times the change of each
// dependency lane and the time coefficient times the elapsed ticks, in saturating Q16.16.
// Only the first min(LANES, 4) lanes are built. An accepted request occupies the block until
// its result is issued, and no new one is taken before that: three lane stages (difference,
// multiply, scale and saturate) run on all lanes and the time lane at once, then the merge
// adds the lane terms and the time term into the accumulator one saturating add per cycle,
// then the error state registers the error and the compare state tests the tolerances. The
// result waits in an output register; a new request is taken while it waits, and a finished
// result stays in the compare state until the register frees.
// In update mode the measurement, lane values and time are latched as the result is issued.
module linear_output_predictor_unit #(
	parameter int LANES = lop_pkg::DEF_LANES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  lop_pkg::req_t                 req_data,
	output logic                          res_valid,
	input  logic                          res_stall,
	output lop_pkg::res_t                 res_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lop_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lop_pkg::VALUE_W-1:0]   cfg_data
);
	import lop_pkg::*;

	localparam int ACT   = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
	localparam int SEL_W = $clog2(ACT + 1);

	state_t                 state_q, state_d;
	logic [SEL_W-1:0]       cnt_q, cnt_d;
	merge_ctrl_t            ctrl;
	logic                   out_free;
	logic                   out_load;
	logic                   take_req;

	req_t                   in_q;
	res_t                   res_q;
	logic                   res_valid_q;

	value_t                 coef_q [ACT];
	value_t                 time_coef_q;
	logic [ABS_TOL_W-1:0]   abs_tol_q;
	logic [REL_TOL_W-1:0]   rel_tol_q;

	value_t                 last_output_q;
	value_t                 last_deps_q [ACT];
	logic [VALUE_W-1:0]     last_time_q;

	value_t                 dep_all [FIELD_LANES];
	value_t                 term [ACT+1];
	value_t                 predicted;
	logic                   mismatch;

	assign dep_all[0] = in_q.dep_value_0;
	assign dep_all[1] = in_q.dep_value_1;
	assign dep_all[2] = in_q.dep_value_2;
	assign dep_all[3] = in_q.dep_value_3;

	assign cfg_ready = 1'b1;

	// Configuration registers
	for (genvar k = 0; k < ACT; k++) begin : g_coef
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				coef_q[k] <= '0;
			end else if (cfg_valid
				&& cfg_index == CFG_IDX_W'(REG_COEF_LANE0) + CFG_IDX_W'(k)) begin
				coef_q[k] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_coef_q <= '0;
			abs_tol_q   <= ABS_TOL_RESET;
			rel_tol_q   <= REL_TOL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TIME_COEF: begin
					time_coef_q <= cfg_data;
				end
				REG_ABS_TOL: begin
					abs_tol_q <= cfg_data[ABS_TOL_W-1:0];
				end
				REG_REL_TOL: begin
					rel_tol_q <= cfg_data[REL_TOL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Lanes
	for (genvar k = 0; k < ACT; k++) begin : g_lane
		lop_lane #(.TIME_LANE(1'b0)) u_lane (
			.clk  (clk),
			.cur  (dep_all[k]),
			.prev (last_deps_q[k]),
			.coef (coef_q[k]),
			.term (term[k])
		);
	end

	lop_lane #(.TIME_LANE(1'b1)) u_time_lane (
		.clk  (clk),
		.cur  (in_q.time_now),
		.prev (last_time_q),
		.coef (time_coef_q),
		.term (term[ACT])
	);

	lop_merge #(.LANES(ACT)) u_merge (
		.clk         (clk),
		.ctrl        (ctrl),
		.sel         (cnt_q),
		.term        (term),
		.last_output (last_output_q),
		.measured    (in_q.measured),
		.mode        (in_q.mode),
		.abs_tol     (abs_tol_q),
		.rel_tol     (rel_tol_q),
		.predicted   (predicted),
		.mismatch    (mismatch)
	);

	// Sequencer
	assign req_stall = (state_q != S_IDLE);
	assign take_req  = req_valid && !req_stall;
	assign out_free  = !res_valid_q || !res_stall;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ctrl     = '0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DIFF;
				end
			end
			S_DIFF: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				state_d = S_TERM;
			end
			S_TERM: begin
				ctrl.load = 1'b1;
				cnt_d     = '0;
				state_d   = S_SUM;
			end
			S_SUM: begin
				ctrl.add = 1'b1;
				if (cnt_q == SEL_W'(ACT)) begin
					state_d = S_ERR;
				end else begin
					cnt_d = SEL_W'(cnt_q + 1'b1);
				end
			end
			S_ERR: begin
				ctrl.err = 1'b1;
				state_d  = S_CMP;
			end
			S_CMP: begin
				// hold until the output register can take the result
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			in_q <= req_data;
		end
		if (out_load) begin
			res_q.predicted <= predicted;
			res_q.mismatch  <= mismatch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Latch the measurement point as an update request retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_output_q <= '0;
			last_time_q   <= '0;
		end else if (out_load && in_q.mode) begin
			last_output_q <= in_q.measured;
			last_time_q   <= in_q.time_now;
		end
	end

	for (genvar k = 0; k < ACT; k++) begin : g_last
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				last_deps_q[k] <= '0;
			end else if (out_load && in_q.mode) begin
				last_deps_q[k] <= dep_all[k];
			end
		end
	end

	a_res_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == S_CMP))
		else $error("result raised outside the compare state");

	a_state_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(last_time_q) |-> $past(state_q == S_CMP && in_q.mode))
		else $error("latched time changed without an update request retiring");

	a_estimate_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !in_q.mode) |=> !res_data.mismatch)
		else $error("estimate request produced a mismatch flag");

	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> (cnt_q <= SEL_W'(ACT)))
		else $error("accumulation index past the time lane");

endmodule

[design/lop_lane.sv]
// One extrapolation lane: change since last update, times coefficient, scaled and saturated.
module lop_lane #(
	parameter bit TIME_LANE = 1'b0
) (
	input  logic                        clk,
	input  logic [lop_pkg::VALUE_W-1:0] cur,
	input  logic [lop_pkg::VALUE_W-1:0] prev,
	input  lop_pkg::value_t             coef,
	output lop_pkg::value_t             term
);
	import lop_pkg::*;

	localparam int SHIFT = TIME_LANE ? 0 : 16;
	localparam int DW    = VALUE_W + 1;
	localparam int PW    = DW + VALUE_W;

	logic signed [DW-1:0] diff_c;
	logic signed [DW-1:0] diff_s1;
	logic signed [PW-1:0] prod_s2;
	logic signed [PW-1:0] shifted;
	logic [PW-VALUE_W:0]  upper;
	value_t               sat_c;
	value_t               term_s3;

	// Time wraps modulo the word, so its change is unsigned; lane values differ exactly.
	always_comb begin
		if (TIME_LANE) begin
			diff_c = $signed({1'b0, VALUE_W'(cur - prev)});
		end else begin
			diff_c = $signed({cur[VALUE_W-1], cur}) - $signed({prev[VALUE_W-1], prev});
		end
	end

	// Arithmetic shift rounds toward minus infinity.
	assign shifted = prod_s2 >>> SHIFT;
	assign upper   = shifted[PW-1:VALUE_W-1];

	always_comb begin
		if ((&upper) || !(|upper)) begin
			sat_c = shifted[VALUE_W-1:0];
		end else begin
			sat_c = shifted[PW-1] ? VAL_MIN : VAL_MAX;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= diff_c;
		prod_s2 <= diff_s1 * coef;
		term_s3 <= sat_c;
	end

	assign term = term_s3;

endmodule

[design/lop_merge.sv]
// Serial saturating accumulation of lane terms and the tolerance check.
module lop_merge #(
	parameter int LANES = lop_pkg::DEF_LANES,
	localparam int SEL_W = $clog2(LANES + 1)
) (
	input  logic                          clk,
	input  lop_pkg::merge_ctrl_t          ctrl,
	input  logic [SEL_W-1:0]              sel,
	input  lop_pkg::value_t               term [LANES+1],
	input  lop_pkg::value_t               last_output,
	input  lop_pkg::value_t               measured,
	input  logic                          mode,
	input  logic [lop_pkg::ABS_TOL_W-1:0] abs_tol,
	input  logic [lop_pkg::REL_TOL_W-1:0] rel_tol,
	output lop_pkg::value_t               predicted,
	output logic                          mismatch
);
	import lop_pkg::*;

	localparam int RW = REL_TOL_W + VALUE_W;

	value_t                  acc_q;
	logic [VALUE_W:0]        err_q;
	logic [VALUE_W-1:0]      big_q;
	logic signed [VALUE_W:0] diff_c;
	logic [VALUE_W:0]        err_c;
	logic [VALUE_W-1:0]      ap_c;
	logic [VALUE_W-1:0]      am_c;
	logic [RW-1:0]           rel_c;

	assign diff_c = $signed({acc_q[VALUE_W-1], acc_q})
		- $signed({measured[VALUE_W-1], measured});
	assign err_c  = diff_c[VALUE_W] ? (VALUE_W+1)'(-diff_c) : diff_c;
	assign ap_c   = acc_q[VALUE_W-1] ? (~acc_q + 1'b1) : acc_q;
	assign am_c   = measured[VALUE_W-1] ? (~measured + 1'b1) : measured;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= last_output;
		end else if (ctrl.add) begin
			acc_q <= sat_add(acc_q, term[sel]);
		end
		if (ctrl.err) begin
			err_q <= err_c;
			big_q <= (ap_c > am_c) ? ap_c : am_c;
		end
	end

	// Relative test as err * 2^16 > rel_tol * max(|pred|, |meas|).
	assign rel_c     = rel_tol * big_q;
	assign mismatch  = mode
		&& (err_q > (VALUE_W+1)'(abs_tol))
		&& ({err_q, 16'b0} > {1'b0, rel_c});
	assign predicted = acc_q;

endmodule
